### hdl/rkc_pkg.sv
`timescale 1ns / 1ps
// Package of the rolling key combo detector: request and action codes, controller
// states and the structs passed between the controller and the row of table cells.
// No dependencies.
package rkc_pkg;

	localparam int KEY_W     = 16;
	localparam int LIMIT_W   = 16;
	localparam int COUNT_W   = 7;
	localparam int ENTRY_W   = 6;
	// Cell index bits carried by the scan word; covers the largest table depth.
	localparam int CELL_IDX_W = 8;

	typedef enum logic [1:0] {
		REQ_PRESS   = 2'd0,
		REQ_RELEASE = 2'd1,
		REQ_TICK    = 2'd2,
		REQ_WRITE   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ACT_PASS    = 3'd0,
		ACT_SWALLOW = 3'd1,
		ACT_EMIT    = 3'd2,
		ACT_TAP     = 3'd3,
		ACT_HOLD    = 3'd4,
		ACT_DROP    = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		CFG_COMBO_COUNT = 2'd0,
		CFG_LEFT_SHIFT  = 2'd1,
		CFG_RIGHT_SHIFT = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_OUT
	} state_t;

	// Values every cell compares against while a press travels down the row.
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [KEY_W-1:0]   held_key;
		logic               shift;
		logic [LIMIT_W-1:0] elapsed;
		logic [COUNT_W-1:0] count;
	} query_t;

	typedef struct packed {
		logic               en;
		logic [ENTRY_W-1:0] index;
		logic [KEY_W-1:0]   key_a;
		logic [KEY_W-1:0]   key_b;
		logic [1:0]         direction;
		logic [LIMIT_W-1:0] limit;
		logic               needs_shift;
	} wr_t;

	// Scan word handed from cell to cell, one cell per cycle.
	typedef struct packed {
		logic                  valid;
		logic                  sec_done;
		logic                  sec_hit;
		logic [CELL_IDX_W-1:0] sec_idx;
		logic                  found;
		logic [LIMIT_W-1:0]    limit;
	} tok_t;

	typedef struct packed {
		action_t            action;
		logic [KEY_W-1:0]   key;
		logic [ENTRY_W-1:0] idx;
		logic               shift;
	} res_t;

endpackage

### hdl/rolling_key_combo_detector.sv
`timescale 1ns / 1ps
// Top level of the rolling key combo detector: controller, held-key state and the
// row of table cells. Depends on rkc_pkg and rkc_cell.
//
//  Channel   Direction  Handshake            Word
//  s_*       in         s_tvalid/s_tready    tuser req_type, tdata event and entry fields
//  m_*       out        m_tvalid/m_tready    tuser action, tdata key/index/shift, tlast
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// A press is accepted, then the scan word is launched and passed through the registered
// cell row, and then one or two result words are delivered. A release delivers one
// result word, a tick one only on a timeout of the held key, and a table write none.
// One word is worked on at a time; s_tready is low while a press is scanned or results
// wait on m_tready. Reset clears the controller, configuration and scan registers; the
// latched press, result words and table entries are undefined until written.
module rolling_key_combo_detector #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata bits from 0: keycode[15:0], shift_held[16], entry_index[22:17],
	// entry_key_a[38:23], entry_key_b[54:39], entry_direction[56:55],
	// entry_limit[72:57], entry_needs_shift[73], zero fill to 80
	input  logic [79:0] s_tdata,
	// tuser: req_type[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata bits from 0: key_out[15:0], combo_index[21:16], shift_restore[22], zero[23]
	output logic [23:0] m_tdata,
	// tuser: action[2:0]
	output logic [2:0]  m_tuser,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import rkc_pkg::*;

	state_t             state_q;
	state_t             state_d;
	logic [COUNT_W-1:0] combo_count_q;
	logic [KEY_W-1:0]   lshift_q;
	logic [KEY_W-1:0]   rshift_q;
	logic               pending_q;
	logic [KEY_W-1:0]   held_key_q;
	logic               held_shift_q;
	logic [LIMIT_W-1:0] elapsed_q;
	logic [LIMIT_W-1:0] longest_q;
	logic [KEY_W-1:0]   key_q;
	logic               shift_q;
	res_t               res0_q;
	res_t               res1_q;
	logic               two_q;
	logic               ptr_q;
	logic               tok_busy_q;

	logic               s_fire;
	logic               m_fire;
	req_t               req;
	logic [KEY_W-1:0]   in_key;
	logic               in_shift;
	logic               in_is_shift;
	logic               key_is_shift;
	logic [LIMIT_W-1:0] elapsed_inc;
	logic               timeout;
	query_t             query;
	wr_t                wr;
	tok_t               tok_chain [0:TABLE_DEPTH];
	tok_t               tok_start;
	tok_t               tok_end;
	logic               sec_hit;
	logic               found;
	res_t               first_res;
	res_t               rel_res;
	res_t               cur_res;

	assign s_fire   = s_tvalid && s_tready;
	assign m_fire   = m_tvalid && m_tready;
	assign req      = req_t'(s_tuser);
	assign in_key   = s_tdata[15:0];
	assign in_shift = s_tdata[16];
	assign in_is_shift  = in_key == lshift_q || in_key == rshift_q;
	assign key_is_shift = key_q == lshift_q || key_q == rshift_q;
	assign elapsed_inc  = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
	assign timeout      = pending_q && elapsed_inc > longest_q;
	assign cfg_ready    = 1'b1;

	assign wr.en          = s_fire && req == REQ_WRITE;
	assign wr.index       = s_tdata[22:17];
	assign wr.key_a       = s_tdata[38:23];
	assign wr.key_b       = s_tdata[54:39];
	assign wr.direction   = s_tdata[56:55];
	assign wr.limit       = s_tdata[72:57];
	assign wr.needs_shift = s_tdata[73];

	assign query.key      = key_q;
	assign query.held_key = held_key_q;
	assign query.shift    = shift_q;
	assign query.elapsed  = elapsed_q;
	assign query.count    = combo_count_q;

	// The scan word enters the row the cycle after the press is latched.
	always_comb begin
		tok_start       = '0;
		tok_start.valid = state_q == ST_SCAN && !tok_chain[TABLE_DEPTH].valid
		                  && !tok_busy_q;
	end

	assign tok_chain[0] = tok_start;
	genvar gi;
	generate
		for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
			rkc_cell #(.CELL_INDEX(gi)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.query  (query),
				.wr     (wr),
				.tok_in (tok_chain[gi]),
				.tok_out(tok_chain[gi+1])
			);
		end
	endgenerate
	assign tok_end = tok_chain[TABLE_DEPTH];

	// Outcome of a scanned press.
	always_comb begin
		sec_hit = pending_q && !key_is_shift && tok_end.sec_done && tok_end.sec_hit;
		found   = !key_is_shift && tok_end.found;
		first_res.action = found ? ACT_SWALLOW : ACT_PASS;
		first_res.key    = key_q;
		first_res.idx    = '0;
		first_res.shift  = 1'b0;
	end

	always_comb begin
		rel_res.key   = in_key;
		rel_res.idx   = '0;
		rel_res.shift = 1'b0;
		if (pending_q && in_key == held_key_q) begin
			rel_res.action = ACT_TAP;
			rel_res.key    = held_key_q;
			rel_res.shift  = held_shift_q;
		end else if (pending_q && in_is_shift) begin
			rel_res.action = ACT_DROP;
		end else begin
			rel_res.action = ACT_PASS;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					case (req)
						REQ_PRESS:   state_d = ST_SCAN;
						REQ_RELEASE: state_d = ST_OUT;
						REQ_TICK:    state_d = timeout ? ST_OUT : ST_IDLE;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (tok_end.valid) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (m_fire && ptr_q == two_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_OUT:  m_tvalid = 1'b1;
			default: begin
				s_tready = 1'b0;
				m_tvalid = 1'b0;
			end
		endcase
	end

	assign cur_res = ptr_q ? res1_q : res0_q;
	assign m_tuser = cur_res.action;
	assign m_tdata = {1'b0, cur_res.shift, cur_res.idx, cur_res.key};
	assign m_tlast = ptr_q == two_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			combo_count_q <= '0;
			lshift_q      <= 16'd225;
			rshift_q      <= 16'd229;
			pending_q     <= 1'b0;
			held_key_q    <= '0;
			held_shift_q  <= 1'b0;
			elapsed_q     <= '0;
			longest_q     <= '0;
			two_q         <= 1'b0;
			ptr_q         <= 1'b0;
			tok_busy_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_COMBO_COUNT: combo_count_q <= cfg_data[COUNT_W-1:0];
					CFG_LEFT_SHIFT:  lshift_q      <= cfg_data;
					CFG_RIGHT_SHIFT: rshift_q      <= cfg_data;
					default:         combo_count_q <= combo_count_q;
				endcase
			end
			if (tok_start.valid) begin
				tok_busy_q <= 1'b1;
			end else if (tok_end.valid) begin
				tok_busy_q <= 1'b0;
			end
			if (m_fire) begin
				ptr_q <= m_tlast ? 1'b0 : 1'b1;
			end
			if (s_fire) begin
				case (req)
					REQ_RELEASE: begin
						two_q <= 1'b0;
						if (pending_q && in_key == held_key_q) begin
							pending_q <= 1'b0;
						end
					end
					REQ_TICK: begin
						two_q     <= 1'b0;
						elapsed_q <= elapsed_inc;
						if (timeout) begin
							pending_q <= 1'b0;
						end
					end
					default: two_q <= two_q;
				endcase
			end
			if (state_q == ST_SCAN && tok_end.valid) begin
				if (sec_hit) begin
					pending_q <= 1'b0;
					two_q     <= 1'b0;
				end else begin
					two_q <= pending_q;
					if (!key_is_shift) begin
						longest_q <= tok_end.limit;
					end
					pending_q <= found;
					if (found) begin
						held_key_q   <= key_q;
						held_shift_q <= shift_q;
						elapsed_q    <= '0;
					end
				end
			end
		end
	end

	// Result words and the latched press carry no reset.
	always_ff @(posedge clk) begin
		if (s_fire && req == REQ_PRESS) begin
			key_q   <= in_key;
			shift_q <= in_shift;
		end
		if (s_fire && req == REQ_RELEASE) begin
			res0_q <= rel_res;
		end
		if (s_fire && req == REQ_TICK) begin
			res0_q.action <= ACT_HOLD;
			res0_q.key    <= held_key_q;
			res0_q.idx    <= '0;
			res0_q.shift  <= held_shift_q;
		end
		if (state_q == ST_SCAN && tok_end.valid) begin
			if (sec_hit) begin
				res0_q.action <= ACT_EMIT;
				res0_q.key    <= held_key_q;
				res0_q.idx    <= tok_end.sec_idx[ENTRY_W-1:0];
				res0_q.shift  <= held_shift_q;
			end else if (pending_q) begin
				res0_q.action <= ACT_TAP;
				res0_q.key    <= held_key_q;
				res0_q.idx    <= '0;
				res0_q.shift  <= held_shift_q;
				res1_q        <= first_res;
			end else begin
				res0_q <= first_res;
			end
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output sides active together");

	a_scan_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		tok_end.valid |-> state_q == ST_SCAN)
		else $error("scan word left the cell row outside a scan");

	a_emit_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ACT_EMIT) |-> m_tlast)
		else $error("combo word not the final word of its press");

	a_one_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_start.valid |=> !tok_start.valid)
		else $error("second scan word launched during one press");

endmodule

### hdl/rkc_cell.sv
`timescale 1ns / 1ps
// One table entry of the combo detector together with its stage of the scan row.
// Depends on rkc_pkg.
module rkc_cell #(
	parameter int CELL_INDEX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rkc_pkg::query_t query,
	input  rkc_pkg::wr_t    wr,
	input  rkc_pkg::tok_t   tok_in,
	output rkc_pkg::tok_t   tok_out
);
	import rkc_pkg::*;

	logic [KEY_W-1:0]   key_a_q;
	logic [KEY_W-1:0]   key_b_q;
	logic [1:0]         dir_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               needs_shift_q;
	tok_t               tok_q;
	tok_t               tok_d;
	logic               active;
	logic               pair_hit;
	logic               first_hit;

	always_ff @(posedge clk) begin
		if (wr.en && {{(CELL_IDX_W-ENTRY_W){1'b0}}, wr.index} == CELL_IDX_W'(CELL_INDEX)) begin
			key_a_q       <= wr.key_a;
			key_b_q       <= wr.key_b;
			dir_q         <= wr.direction;
			limit_q       <= wr.limit;
			needs_shift_q <= wr.needs_shift;
		end
	end

	assign active = {2'b00, query.count} > (COUNT_W+2)'(CELL_INDEX);
	assign pair_hit = (dir_q[0] && query.held_key == key_a_q && query.key == key_b_q) ||
	                  (dir_q[1] && query.held_key == key_b_q && query.key == key_a_q);
	assign first_hit = ((dir_q[0] && query.key == key_a_q) || (dir_q[1] && query.key == key_b_q))
	                   && !(needs_shift_q && !query.shift);

	always_comb begin
		tok_d = tok_in;
		if (tok_in.valid && active) begin
			// Only the first matching pair decides the second key.
			if (pair_hit && !tok_in.sec_done) begin
				tok_d.sec_done = 1'b1;
				tok_d.sec_hit  = query.elapsed <= limit_q;
				tok_d.sec_idx  = CELL_IDX_W'(CELL_INDEX);
			end
			if (first_hit) begin
				tok_d.found = 1'b1;
				if (limit_q > tok_in.limit) begin
					tok_d.limit = limit_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule
